### hw/rtl/wrd_pkg.sv
// Shared types and constants for the windowed average rise detector.
`default_nettype none

package wrd_pkg;

    localparam int FIELD_W   = 16;
    localparam int WIN_LEN_W = 5;
    localparam int NUM_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 5'd5;
    localparam logic [NUM_W-1:0]     NUM_RESET     = 8'd9;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_NUMERATOR = 2'd1;

    typedef struct packed {
        logic step;
        logic close;
    } chan_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/wrd_channel.sv
// Per-channel window accumulator with the threshold compare against the previous window.
`default_nettype none

module wrd_channel #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 20
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire wrd_pkg::chan_ctrl_t        ctrl,
    input  wire [SAMPLE_BITS-1:0]           sample,
    input  wire [wrd_pkg::NUM_W-1:0]        numerator,
    output logic                            rise
);
    import wrd_pkg::*;

    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [SUM_W-1:0]       prev_reg;
    logic [SUM_W-1:0]       prev_next;
    logic [SUM_W-1:0]       sum_new;
    logic [SUM_W+NUM_W-1:0] lhs;
    logic [SUM_W+NUM_W-1:0] rhs;

    assign sum_new = sum_reg + SUM_W'(sample);

    // Exact form of avg_new > (numerator / 8) * avg_old for equal window lengths.
    assign lhs  = (SUM_W+NUM_W)'({sum_new, 3'b000});
    assign rhs  = (SUM_W+NUM_W)'(numerator) * (SUM_W+NUM_W)'(prev_reg);
    assign rise = lhs > rhs;

    always_comb
    begin
        sum_next  = sum_reg;
        prev_next = prev_reg;
        if (ctrl.step)
        begin
            if (ctrl.close)
            begin
                sum_next  = '0;
                prev_next = sum_new;
            end
            else
            begin
                sum_next = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            prev_reg <= prev_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/windowed_average_rise_detector.sv
// Top level of the windowed average rise detector: input stage, window control, result register.
// One sample pair is taken per beat and a new beat can be accepted every clock cycle unless a
// waiting result stalls the input; each beat passes through an input register and, if it closes a
// window on which at least one channel rose, moves on to the result register when that register is
// free (a waiting result holds the beat in the input register). Both channels sum
// window_length samples (0 counts as 1, values above MAX_WINDOW saturate) and flag a rise when
// 8 * sum exceeds rise_numerator * previous sum; windows without a rise produce no output
// beat. Configuration writes are meant to happen only while the block is idle.
`default_nettype none

module windowed_average_rise_detector #(
    parameter int MAX_WINDOW  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire [wrd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [wrd_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // [15:0] sample_a, [31:16] sample_b
    input  wire [wrd_pkg::IN_DATA_W-1:0]         s_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // [0] rise_a, [1] rise_b, [17:2] value_a, [33:18] value_b, [39:34] zero
    output logic [wrd_pkg::OUT_DATA_W-1:0]       m_tdata
);
    import wrd_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    logic [WIN_LEN_W-1:0]   win_len_reg;
    logic [NUM_W-1:0]       num_reg;

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_a_reg;
    logic [SAMPLE_BITS-1:0] in_b_reg;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       count_inc;
    logic [CNT_W-1:0]       eff_window;
    logic                   win_close;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_rise_a_reg;
    logic                   out_rise_b_reg;
    logic [FIELD_W-1:0]     out_a_reg;
    logic [FIELD_W-1:0]     out_b_reg;

    logic                   out_free;
    logic                   advance;
    logic                   out_load;
    logic                   rise_a;
    logic                   rise_b;
    chan_ctrl_t             ctrl;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= WIN_LEN_RESET;
            num_reg     <= NUM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH:  win_len_reg <= cfg_data[WIN_LEN_W-1:0];
                REG_RISE_NUMERATOR: num_reg     <= cfg_data[NUM_W-1:0];
                default:            ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_a_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_b_reg <= s_tdata[FIELD_W+SAMPLE_BITS-1:FIELD_W];
        end
    end

    // Window length as used: zero acts as one, large values clamp to MAX_WINDOW.
    always_comb
    begin
        if (win_len_reg == '0)
            eff_window = CNT_W'(1);
        else if (int'(win_len_reg) > MAX_WINDOW)
            eff_window = CNT_W'(MAX_WINDOW);
        else
            eff_window = CNT_W'(win_len_reg);
    end

    assign count_inc = count_reg + CNT_W'(1);
    assign win_close = count_inc >= eff_window;
    assign ctrl      = '{step: advance, close: win_close};

    always_comb
    begin
        count_next = count_reg;
        if (advance)
            count_next = ctrl.close ? '0 : count_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    wrd_channel #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_chan_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample    (in_a_reg),
        .numerator (num_reg),
        .rise      (rise_a)
    );

    wrd_channel #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_chan_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample    (in_b_reg),
        .numerator (num_reg),
        .rise      (rise_b)
    );

    // Result register
    assign out_load = advance && ctrl.close && (rise_a || rise_b);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rise_a_reg <= rise_a;
            out_rise_b_reg <= rise_b;
            out_a_reg      <= FIELD_W'(in_a_reg);
            out_b_reg      <= FIELD_W'(in_b_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_b_reg, out_a_reg, out_rise_b_reg, out_rise_a_reg};

endmodule

`default_nettype wire

### tb/windowed_average_rise_detector_test.sv
// Self-checking testbench for the windowed average rise detector.
`timescale 1ns / 1ps

module windowed_average_rise_detector_test;

    import wrd_pkg::*;

    localparam int MAX_SPAN      = 16;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 150;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic        rise_a;
        logic        rise_b;
        logic [15:0] value_a;
        logic [15:0] value_b;
    } rise_event_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Detector state as the block should hold it.
    logic [WIN_LEN_W-1:0] win_len = WIN_LEN_RESET;
    logic [NUM_W-1:0]     rise_num = NUM_RESET;
    logic [19:0]          acc_a = '0;
    logic [19:0]          acc_b = '0;
    logic [19:0]          last_a = '0;
    logic [19:0]          last_b = '0;
    logic [4:0]           fill_count = '0;

    logic [IN_DATA_W-1:0] pending_pairs[$];
    rise_event_t          expected_events[$];

    int  beats_queued = 0;
    int  beats_taken = 0;
    int  events_checked = 0;
    int  reg_writes = 0;
    int  error_count = 0;
    logic took_beat = 1'b0;

    int  burst_left = 1;
    int  gap_left = 0;
    bit  sender_gappy = 1'b0;

    int  stall_token = 0;
    int  stall_seen = 0;
    int  hold_left = 0;
    int  rx_cycle = 0;
    int  rx_mode = 0;

    windowed_average_rise_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic int window_span();
        int span;
        span = win_len;
        if (span == 0)
            span = 1;
        if (span > MAX_SPAN)
            span = MAX_SPAN;
        return span;
    endfunction

    // Adds one sample pair to the window sums and queues a rise event when the
    // window closes with at least one channel above the threshold.
    function automatic void predict_window_close(input logic [IN_DATA_W-1:0] pair);
        logic [15:0] a;
        logic [15:0] b;
        logic [31:0] scaled_a;
        logic [31:0] scaled_b;
        logic [31:0] bound_a;
        logic [31:0] bound_b;
        rise_event_t ev;
        a = pair[15:0];
        b = pair[31:16];
        acc_a = acc_a + a;
        acc_b = acc_b + b;
        fill_count = fill_count + 1'b1;
        if (fill_count >= window_span()) begin
            scaled_a = {12'd0, acc_a} << 3;
            scaled_b = {12'd0, acc_b} << 3;
            bound_a  = {24'd0, rise_num} * {12'd0, last_a};
            bound_b  = {24'd0, rise_num} * {12'd0, last_b};
            ev.rise_a  = scaled_a > bound_a;
            ev.rise_b  = scaled_b > bound_b;
            ev.value_a = a;
            ev.value_b = b;
            last_a = acc_a;
            last_b = acc_b;
            acc_a = '0;
            acc_b = '0;
            fill_count = '0;
            if (ev.rise_a || ev.rise_b)
                expected_events.push_back(ev);
        end
    endfunction

    function automatic void check_event(input logic [OUT_DATA_W-1:0] beat);
        rise_event_t ev;
        if (expected_events.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, beat);
            error_count++;
            return;
        end
        ev = expected_events.pop_front();
        events_checked++;
        if (beat[0] !== ev.rise_a) begin
            $display("%0t: rise_a expected %b actual %b", $time, ev.rise_a, beat[0]);
            error_count++;
        end
        if (beat[1] !== ev.rise_b) begin
            $display("%0t: rise_b expected %b actual %b", $time, ev.rise_b, beat[1]);
            error_count++;
        end
        if (beat[17:2] !== ev.value_a) begin
            $display("%0t: value_a expected %h actual %h", $time, ev.value_a, beat[17:2]);
            error_count++;
        end
        if (beat[33:18] !== ev.value_b) begin
            $display("%0t: value_b expected %h actual %h", $time, ev.value_b, beat[33:18]);
            error_count++;
        end
        if (beat[39:34] !== 6'd0) begin
            $display("%0t: padding expected 00 actual %h", $time, beat[39:34]);
            error_count++;
        end
    endfunction

    // Both handshakes are sampled here, before the block updates on this edge.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            took_beat <= 1'b0;
        end else begin
            took_beat <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                predict_window_close(s_tdata);
                beats_taken++;
            end
            if (m_tvalid && m_tready)
                check_event(m_tdata);
        end
    end

    // Sample driver: bursts of random length with optional gaps between them.
    always @(negedge clk)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || took_beat) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_pairs.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = sender_gappy ? $urandom_range(1, 8) : 0;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: switches between always ready, random and periodic stalls,
    // and takes one long hold-off whenever the stimulus asks for it.
    always @(negedge clk)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (stall_token != stall_seen) begin
                stall_seen = stall_token;
                hold_left = HOLD_CYCLES;
            end
            if (rx_cycle % 97 == 0)
                rx_mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_mode == 0) begin
                m_tready <= 1'b1;
            end else if (rx_mode == 1) begin
                m_tready <= ($urandom_range(0, 9) >= 3);
            end else begin
                m_tready <= (rx_cycle % 5) != 0;
            end
        end
    end

    task automatic queue_pair(input logic [15:0] a, input logic [15:0] b);
        pending_pairs.push_back({b, a});
        beats_queued++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (beats_taken != beats_queued || expected_events.size() != 0);
        // A window that closes without a rise leaves no result to wait for.
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_WINDOW_LENGTH)
            win_len = data[WIN_LEN_W-1:0];
        else if (idx == REG_RISE_NUMERATOR)
            rise_num = data;
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample(input int mode, input int idx, input int lane);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'((idx * 173 * (lane + 1)) + $urandom_range(0, 127));
            // Levels alternate per window so that rises show up regularly.
            2: return 16'(((idx / window_span()) % 2 == lane) ? $urandom_range(40000, 65535)
                                                              : $urandom_range(0, 20000));
            3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom_range(0, 15));
        endcase
    endfunction

    initial
    begin
        int random_queued;
        int mode;
        int len;
        int pick;
        logic [CFG_DATA_W-1:0] wdata;
        random_queued = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First window after reset compares against zero previous sums.
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'hFFFF, 16'h0001);
        wait_idle();

        // Zero length acts as one sample; the second window at top ratio does not rise.
        write_reg(REG_WINDOW_LENGTH, 8'd0);
        write_reg(REG_RISE_NUMERATOR, 8'd255);
        queue_pair(16'hFFFF, 16'hFFFF);
        queue_pair(16'hFFFF, 16'hFFFF);
        wait_idle();

        // Upper data bits are dropped and 31 saturates to the largest window.
        write_reg(REG_WINDOW_LENGTH, 8'hFF);
        write_reg(REG_RISE_NUMERATOR, 8'd4);
        write_reg(REG_SPARE_2, 8'hFF);
        write_reg(REG_SPARE_3, 8'hA5);
        queue_pair(16'h0001, 16'hFFFE);
        queue_pair(16'h8000, 16'h7FFF);
        queue_pair(16'hAAAA, 16'h5555);
        queue_pair(16'h5555, 16'hAAAA);
        queue_pair(16'hFFFF, 16'h0000);
        queue_pair(16'h0000, 16'hFFFF);
        queue_pair(16'h1234, 16'hFEDC);
        wait_idle();

        // Shortening the window below the current fill closes it on the next sample.
        write_reg(REG_WINDOW_LENGTH, 8'd3);
        queue_pair(16'h7FFF, 16'h8001);
        wait_idle();

        // Every beat raises an event here, so the long receiver hold-off backs up the input.
        write_reg(REG_WINDOW_LENGTH, 8'd1);
        write_reg(REG_RISE_NUMERATOR, 8'd0);
        stall_token++;
        for (int i = 0; i < 60; i++)
            queue_pair(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
        wait_idle();

        while (random_queued < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0) begin
                wait_idle();
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    wdata = 8'($urandom_range(1, 6));
                else if (pick < 9)
                    wdata = 8'($urandom_range(7, 16));
                else
                    wdata = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(17, 31));
                wdata[7:5] = 3'($urandom_range(0, 7));
                write_reg(REG_WINDOW_LENGTH, wdata);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    wdata = 8'($urandom_range(8, 12));
                else if (pick < 8)
                    wdata = 8'($urandom_range(0, 7));
                else
                    wdata = 8'($urandom_range(13, 255));
                write_reg(REG_RISE_NUMERATOR, wdata);
                if ($urandom_range(0, 7) == 0)
                    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                              8'($urandom_range(0, 255)));
            end
            sender_gappy = $urandom_range(0, 3) != 0;
            mode = $urandom_range(0, 4);
            len = $urandom_range(20, 80);
            for (int i = 0; i < len; i++)
                queue_pair(pick_sample(mode, i, 0), pick_sample(mode, i, 1));
            random_queued += len;
        end

        wait_idle();
        repeat (10) @(negedge clk);
        $display("Run covered %0d sample beats, %0d rise events and %0d register writes.",
                 beats_taken, events_checked, reg_writes);
        $display("Window lengths 0 to 31, numerators 0 to 255, and a long output stall.");
        if (error_count == 0 && expected_events.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Timeout with %0d events still expected.", expected_events.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
